[rtl/pn_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// pn_pkg
// Shared types and constants of the path normalizer: character codes,
// path kind, controller states and the status group of the output sequencer.
// ============================================================================
package pn_pkg;

    // default store depth in characters
    localparam int PN_DEPTH_DEF = 64;

    // character codes
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // kind of the path seen so far
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_REL,
        KIND_ABS
    } kind_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_POP_RD,
        ST_POP_CHK,
        ST_FINAL,
        ST_LEN,
        ST_EMIT
    } pn_state_t;

    // output sequencer status toward the controller
    typedef struct packed {
        logic active;
        logic done;
    } emit_stat_t;

endpackage

[rtl/pn_store.sv]
`timescale 1ns / 1ps
// ============================================================================
// pn_store
// Path character store: one write port and one read port, read data
// registered.
// ============================================================================
module pn_store
    import pn_pkg::*;
#(
    parameter int DEPTH = PN_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
)(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/pn_emit.sv]
`timescale 1ns / 1ps
// ============================================================================
// pn_emit
// Output sequencer: walks the store from index 0 to len-1, one read per
// cycle, and raises the strobe in the cycle after each read, when the read data is out.
// ============================================================================
module pn_emit
    import pn_pkg::*;
#(
    parameter int DEPTH = PN_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [AW-1:0] len,
    output logic          re,
    output logic [AW-1:0] raddr,
    output emit_stat_t    stat,
    output logic          strobe,
    output logic          out_last
);

    logic          active_reg, active_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] len_reg, len_next;
    logic          vld_reg, vld_next;
    logic          lst_reg, lst_next;
    logic          at_end;

    // read issue and status
    always_comb
    begin
        at_end      = (idx_reg == (len_reg - AW'(1)));
        re          = active_reg;
        raddr       = idx_reg;
        stat.active = active_reg;
        stat.done   = active_reg && at_end;
    end

    // sequencer next values
    always_comb
    begin
        active_next = active_reg && !at_end;
        idx_next    = active_reg ? (idx_reg + AW'(1)) : idx_reg;
        len_next    = len_reg;
        if (go)
        begin
            active_next = 1'b1;
            idx_next    = '0;
            len_next    = len;
        end
        vld_next = active_reg;
        lst_next = active_reg && at_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            len_reg    <= '0;
            vld_reg    <= 1'b0;
            lst_reg    <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            vld_reg    <= vld_next;
            lst_reg    <= lst_next;
        end
    end

    assign strobe   = vld_reg;
    assign out_last = lst_reg;

endmodule

[rtl/pn_ctrl.sv]
`timescale 1ns / 1ps
// ============================================================================
// pn_ctrl
// Path controller: takes at most one character per request, keeps the fill position
// and the open component, writes characters and separators into the store,
// walks the store back for a parent-directory component and starts output.
// ============================================================================
module pn_ctrl
    import pn_pkg::*;
#(
    parameter int DEPTH = PN_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int PW = $clog2(DEPTH + 1)
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [7:0]    ch,
    input  logic          last,
    input  logic          empty_req,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [7:0]    mem_wdata,
    output logic          pop_re,
    output logic [AW-1:0] pop_raddr,
    input  logic [7:0]    mem_rdata,
    output logic          emit_go,
    output logic [AW-1:0] emit_len,
    input  emit_stat_t    emit_stat
);

    pn_state_t      state_reg, state_next;
    logic [7:0]     ch_reg;
    logic           last_reg;
    logic           empty_reg;
    logic [PW-1:0]  fp_reg, fp_next;
    logic [PW-1:0]  clen_reg, clen_next;
    logic [7:0]     head0_reg, head0_next;
    logic [7:0]     head1_reg, head1_next;
    kind_t          kind_reg, kind_next;
    logic           halted_reg, halted_next;
    logic           eslash_reg, eslash_next;

    logic           fp_gt1;
    logic [PW-1:0]  fp_dec;
    logic [PW:0]    base;
    logic [PW+1:0]  tip;
    logic           sep_need;
    logic           tip_ovf;
    logic           cl_skip;
    logic           cl_up;
    logic           take;
    logic           char_slash;
    logic           char_nul;
    logic           close_do;
    logic           pop_start;
    logic           trim;
    logic [PW-1:0]  len_val;

    // request capture
    always_ff @(posedge clk)
    begin
        if (start && (state_reg == ST_IDLE))
        begin
            ch_reg    <= ch;
            last_reg  <= last;
            empty_reg <= empty_req;
        end
    end

    // component and position decode
    always_comb
    begin
        fp_gt1     = (fp_reg > PW'(1));
        fp_dec     = fp_reg - PW'(1);
        // start of the next component, after a separator if one is needed
        base       = {1'b0, fp_reg} + {{PW{1'b0}}, (fp_gt1 && !eslash_reg)};
        tip        = {1'b0, base} + {2'b00, clen_reg};
        sep_need   = fp_gt1 && !eslash_reg && (fp_reg < PW'(DEPTH));
        tip_ovf    = (tip >= (PW+2)'(DEPTH));
        cl_skip    = (clen_reg == '0) ||
                     ((clen_reg == PW'(1)) && (head0_reg == CH_DOT));
        cl_up      = (clen_reg == PW'(2)) && (head0_reg == CH_DOT) &&
                     (head1_reg == CH_DOT);
        take       = !empty_reg && !halted_reg;
        char_slash = (ch_reg == CH_SLASH);
        char_nul   = (ch_reg == CH_NUL);
        close_do   = ((state_reg == ST_STEP) && take && (kind_reg == KIND_ABS) &&
                      (char_nul || char_slash)) ||
                     ((state_reg == ST_FINAL) && (kind_reg == KIND_ABS) && !halted_reg);
        pop_start  = close_do && cl_up && fp_gt1;
        // result length, trailing slash trimmed
        trim       = (kind_reg == KIND_ABS) && fp_gt1 && eslash_reg;
        len_val    = fp_reg - {{(PW-1){1'b0}}, trim};
        if (len_val > PW'(DEPTH - 1))
        begin
            len_val = PW'(DEPTH - 1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (pop_start)
                begin
                    state_next = ST_POP_RD;
                end
                else if (last_reg)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP_RD:
            begin
                state_next = ST_POP_CHK;
            end
            ST_POP_CHK:
            begin
                if (mem_rdata == CH_SLASH)
                begin
                    state_next = last_reg ? ST_FINAL : ST_IDLE;
                end
                else
                begin
                    state_next = ST_POP_RD;
                end
            end
            ST_FINAL:
            begin
                state_next = pop_start ? ST_POP_RD : ST_LEN;
            end
            ST_LEN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_stat.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and store accesses
    always_comb
    begin
        fp_next     = fp_reg;
        clen_next   = clen_reg;
        head0_next  = head0_reg;
        head1_next  = head1_reg;
        kind_next   = kind_reg;
        halted_next = halted_reg;
        eslash_next = eslash_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = ch_reg;
        pop_re      = 1'b0;
        pop_raddr   = fp_dec[AW-1:0];
        emit_go     = 1'b0;
        emit_len    = len_val[AW-1:0];

        case (state_reg)
            ST_STEP:
            begin
                if (take)
                begin
                    if (char_nul)
                    begin
                        // end of string: rest of the path ignored
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        case (kind_reg)
                            KIND_NONE:
                            begin
                                kind_next   = char_slash ? KIND_ABS : KIND_REL;
                                mem_we      = 1'b1;
                                mem_waddr   = '0;
                                fp_next     = PW'(1);
                                eslash_next = char_slash;
                            end
                            KIND_REL:
                            begin
                                if (fp_reg < PW'(DEPTH - 1))
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = fp_reg[AW-1:0];
                                    fp_next   = fp_reg + PW'(1);
                                end
                            end
                            default:
                            begin
                                // character of the open component
                                if (!char_slash)
                                begin
                                    if (clen_reg == '0)
                                    begin
                                        head0_next = ch_reg;
                                        head1_next = '0;
                                    end
                                    else if (clen_reg == PW'(1))
                                    begin
                                        head1_next = ch_reg;
                                    end
                                    if (!tip_ovf)
                                    begin
                                        mem_we    = 1'b1;
                                        mem_waddr = tip[AW-1:0];
                                    end
                                    if (clen_reg < PW'(DEPTH))
                                    begin
                                        clen_next = clen_reg + PW'(1);
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            ST_POP_RD:
            begin
                pop_re = 1'b1;
            end
            ST_POP_CHK:
            begin
                if (mem_rdata == CH_SLASH)
                begin
                    eslash_next = 1'b1;
                end
                else
                begin
                    fp_next = fp_dec;
                end
            end
            ST_LEN:
            begin
                emit_go = 1'b1;
                if (kind_reg == KIND_NONE)
                begin
                    // empty path reads back as root
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = CH_SLASH;
                    emit_len  = AW'(1);
                end
            end
            ST_EMIT:
            begin
                if (emit_stat.done)
                begin
                    fp_next     = '0;
                    clen_next   = '0;
                    head0_next  = '0;
                    head1_next  = '0;
                    kind_next   = KIND_NONE;
                    halted_next = 1'b0;
                    eslash_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        // component close
        if (close_do)
        begin
            clen_next  = '0;
            head0_next = '0;
            head1_next = '0;
            if (cl_up)
            begin
                // parent: drop a trailing slash, then walk back in the store
                if (fp_gt1 && eslash_reg)
                begin
                    fp_next = fp_dec;
                end
            end
            else if (!cl_skip)
            begin
                if (sep_need)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = fp_reg[AW-1:0];
                    mem_wdata = CH_SLASH;
                end
                if (tip_ovf)
                begin
                    fp_next     = base[PW-1:0];
                    halted_next = 1'b1;
                    eslash_next = 1'b1;
                end
                else
                begin
                    fp_next     = tip[PW-1:0];
                    eslash_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fp_reg     <= '0;
            clen_reg   <= '0;
            head0_reg  <= '0;
            head1_reg  <= '0;
            kind_reg   <= KIND_NONE;
            halted_reg <= 1'b0;
            eslash_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fp_reg     <= fp_next;
            clen_reg   <= clen_next;
            head0_reg  <= head0_next;
            head1_reg  <= head1_next;
            kind_reg   <= kind_next;
            halted_reg <= halted_next;
            eslash_reg <= eslash_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[rtl/path_normalizer_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// path_normalizer_unit
// Streaming path normalizer: characters of a path come in one per request,
// the normalized path leaves one character per strobe after the last one.
// ============================================================================
//
//  channel   handshake            payload
//  --------  -------------------  ------------------------------
//  request   start / busy         ch, last, empty_req
//  result    strobe (no stall)    out_ch, out_last
//
//  A character request passes through capture, then the store update.
//  A ".." component walks the store back with one store read and one compare
//  per character removed, and one more of each for the final slash.
//  The last request adds a close state (entered again when the close walks
//  back), a length state and one store read per result character; each
//  strobe comes with the registered read data.
//  Reset needs no clearing pass: only written store entries are ever read.
//  Results are shown for one cycle each and cannot be held off.
//
module path_normalizer_unit
    import pn_pkg::*;
#(
    parameter int DEPTH = PN_DEPTH_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] ch,
    input  logic       last,
    input  logic       empty_req,
    output logic [7:0] out_ch,
    output logic       out_last,
    output logic       strobe
);

    localparam int AW = $clog2(DEPTH);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    logic          pop_re;
    logic [AW-1:0] pop_raddr;
    logic          emit_re;
    logic [AW-1:0] emit_raddr;
    logic          emit_go;
    logic [AW-1:0] emit_len;
    emit_stat_t    emit_stat;

    pn_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .ch        (ch),
        .last      (last),
        .empty_req (empty_req),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .pop_re    (pop_re),
        .pop_raddr (pop_raddr),
        .mem_rdata (mem_rdata),
        .emit_go   (emit_go),
        .emit_len  (emit_len),
        .emit_stat (emit_stat)
    );

    pn_emit #(
        .DEPTH (DEPTH)
    ) u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (emit_go),
        .len      (emit_len),
        .re       (emit_re),
        .raddr    (emit_raddr),
        .stat     (emit_stat),
        .strobe   (strobe),
        .out_last (out_last)
    );

    // read port shared by the back walk and the output sequencer
    assign mem_re    = pop_re || emit_re;
    assign mem_raddr = emit_stat.active ? emit_raddr : pop_raddr;

    pn_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_ch = mem_rdata;

endmodule

[rtl/pn_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// pn_checker
// Port-level checks of the path normalizer: request sequencing against the
// result strobe, bound to the top level.
// ============================================================================
module pn_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [7:0] ch,
    input logic       last,
    input logic       empty_req,
    input logic [7:0] out_ch,
    input logic       out_last,
    input logic       strobe
);

    // final-character mark only comes with a strobe
    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        out_last |-> strobe)
        else $error("out_last without strobe");

    // a result always belongs to a request still in work in the previous cycle
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("strobe without preceding busy");

    // an accepted request keeps the unit busy and silent in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !strobe))
        else $error("request accepted but unit not busy or strobing");

    // a result burst ends after its final character
    a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && out_last) |=> !strobe)
        else $error("strobe after final character");

endmodule

bind path_normalizer_unit pn_checker u_pn_checker (.*);

[test/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for path_normalizer_unit. Paths are fed in one
// character per request while a behavioral copy of the normalizer predicts
// every output character. Each strobe is checked against the oldest expected
// character. Directed paths cover the corner cases first, then random paths
// run under three sender idle patterns.
// ============================================================================
module tb;
    import pn_pkg::*;

    localparam int DEPTH       = PN_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } path_char_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [7:0] ch;
    logic       last;
    logic       empty_req;
    logic [7:0] out_ch;
    logic       out_last;
    logic       strobe;

    // normalizer state as predicted
    logic [7:0]  norm_store [DEPTH];
    int          norm_fill;
    int          norm_clen;
    logic [15:0] norm_head;
    kind_t       norm_kind;
    bit          norm_halted;

    path_char_t  expected_chars [$];
    logic [7:0]  path_chars [$];
    int          gap_pct;
    int          chars_sent;
    int          mismatch_count;
    int          stall_cycles;

    path_normalizer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .ch        (ch),
        .last      (last),
        .empty_req (empty_req),
        .out_ch    (out_ch),
        .out_last  (out_last),
        .strobe    (strobe)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // path prediction
    // ------------------------------------------------------------------------

    function automatic void norm_clear();
        foreach (norm_store[i])
            norm_store[i] = CH_NUL;
        norm_fill   = 0;
        norm_clen   = 0;
        norm_head   = '0;
        norm_kind   = KIND_NONE;
        norm_halted = 1'b0;
    endfunction

    // start of the next component, past a separator if one is needed
    function automatic int norm_base();
        int p;
        p = norm_fill;
        if (p > 1 && p <= DEPTH && norm_store[p - 1] != CH_SLASH)
            p++;
        return p;
    endfunction

    function automatic void norm_close();
        int         len;
        int         p;
        logic [7:0] c0;
        logic [7:0] c1;
        len = norm_clen;
        c0  = norm_head[7:0];
        c1  = norm_head[15:8];
        norm_clen = 0;
        norm_head = '0;
        if (len == 0)
            return;
        // single dot is dropped
        if (len == 1 && c0 == CH_DOT)
            return;
        // double dot pops one component, never above root
        if (len == 2 && c0 == CH_DOT && c1 == CH_DOT)
        begin
            if (norm_fill > 1 && norm_fill <= DEPTH)
            begin
                if (norm_store[norm_fill - 1] == CH_SLASH)
                    norm_fill--;
                while (norm_fill > 0 && norm_store[norm_fill - 1] != CH_SLASH)
                    norm_fill--;
            end
            return;
        end
        p = norm_base();
        if (p != norm_fill && norm_fill < DEPTH)
            norm_store[norm_fill] = CH_SLASH;
        // component does not fit: stop taking input
        if (p + len >= DEPTH)
        begin
            norm_fill   = p;
            norm_halted = 1'b1;
            return;
        end
        norm_fill = p + len;
    endfunction

    function automatic void norm_take(input logic [7:0] c);
        int idx;
        if (norm_halted)
            return;
        // zero byte ends the string
        if (c == CH_NUL)
        begin
            if (norm_kind == KIND_ABS)
                norm_close();
            norm_halted = 1'b1;
            return;
        end
        if (norm_kind == KIND_NONE)
        begin
            norm_kind     = (c == CH_SLASH) ? KIND_ABS : KIND_REL;
            norm_store[0] = c;
            norm_fill     = 1;
            return;
        end
        // relative path kept as given, truncated
        if (norm_kind == KIND_REL)
        begin
            if (norm_fill < DEPTH - 1)
            begin
                norm_store[norm_fill] = c;
                norm_fill++;
            end
            return;
        end
        if (c == CH_SLASH)
        begin
            norm_close();
            return;
        end
        if (norm_clen == 0)
            norm_head = {8'h00, c};
        else if (norm_clen == 1)
            norm_head[15:8] = c;
        idx = norm_base() + norm_clen;
        if (idx < DEPTH)
            norm_store[idx] = c;
        if (norm_clen < DEPTH)
            norm_clen++;
    endfunction

    // one accepted request; a last request queues the whole output path
    function automatic void norm_step(input logic [7:0] c, input logic is_last,
                                      input logic no_char);
        int         n;
        path_char_t r;
        if (!no_char)
            norm_take(c);
        if (!is_last)
            return;
        if (norm_kind == KIND_ABS && !norm_halted)
            norm_close();
        if (norm_kind == KIND_NONE)
        begin
            r.ch   = CH_SLASH;
            r.last = 1'b1;
            expected_chars.push_back(r);
            norm_clear();
            return;
        end
        n = norm_fill;
        if (n > DEPTH)
            n = DEPTH;
        // trailing slash trimmed unless the path is the root
        if (norm_kind == KIND_ABS && n > 1 && norm_store[n - 1] == CH_SLASH)
            n--;
        if (n > DEPTH - 1)
            n = DEPTH - 1;
        for (int i = 0; i < n; i++)
        begin
            r.ch   = norm_store[i];
            r.last = (i + 1 == n);
            expected_chars.push_back(r);
        end
        norm_clear();
    endfunction

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------

    task automatic send_req(input logic [7:0] c, input logic is_last, input logic no_char);
        @(negedge clk);
        // random sender gaps
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start     <= 1'b1;
        ch        <= c;
        last      <= is_last;
        empty_req <= no_char;
        do
            @(posedge clk);
        while (busy);
        norm_step(c, is_last, no_char);
        if (!no_char)
            chars_sent++;
    endtask

    // send the buffered path, optionally with characterless requests mixed in
    task automatic send_path(input bit tail_empty, input int noise_pct);
        int n;
        n = path_chars.size();
        if (n == 0)
        begin
            send_req(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            return;
        end
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            send_req(path_chars[i], (i == n - 1) && !tail_empty, 1'b0);
        end
        if (tail_empty)
            send_req(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    function automatic void load_text(input string s);
        path_chars.delete();
        for (int i = 0; i < s.len(); i++)
            path_chars.push_back(s[i]);
    endfunction

    // ------------------------------------------------------------------------
    // random path building
    // ------------------------------------------------------------------------

    function automatic logic [7:0] name_char();
        string      pool;
        logic [7:0] c;
        pool = "abxyz.-_";
        if ($urandom_range(0, 9) < 7)
            return pool[$urandom_range(0, pool.len() - 1)];
        c = 8'($urandom_range(1, 255));
        if (c == CH_SLASH)
            c = CH_DOT;
        return c;
    endfunction

    function automatic void add_name(input int len);
        for (int i = 0; i < len; i++)
            path_chars.push_back(name_char());
    endfunction

    // components separated by one or two slashes
    function automatic void add_abs_components(input int n, input int max_len);
        int sel;
        for (int k = 0; k < n; k++)
        begin
            path_chars.push_back(CH_SLASH);
            if ($urandom_range(0, 4) == 0)
                path_chars.push_back(CH_SLASH);
            sel = $urandom_range(0, 99);
            if (sel < 15)
                path_chars.push_back(CH_DOT);
            else if (sel < 35)
                repeat (2) path_chars.push_back(CH_DOT);
            else if (sel < 40)
                repeat (3) path_chars.push_back(CH_DOT);
            else
                add_name($urandom_range(1, max_len));
        end
    endfunction

    function automatic void build_random_path();
        int         sel;
        int         len;
        logic [7:0] c;
        path_chars.delete();
        sel = $urandom_range(0, 99);
        if (sel < 3)
            return;
        if (sel < 63)
        begin
            // well-formed absolute path
            add_abs_components($urandom_range(0, 7), 6);
            if (path_chars.size() == 0 || $urandom_range(0, 2) == 0)
                path_chars.push_back(CH_SLASH);
        end
        else if (sel < 73)
        begin
            // long components, likely to overflow the store
            repeat ($urandom_range(1, 4))
            begin
                path_chars.push_back(CH_SLASH);
                add_name($urandom_range(8, 70));
            end
        end
        else if (sel < 83)
        begin
            // relative path, sometimes past the truncation point
            c = 8'($urandom_range(1, 255));
            if (c == CH_SLASH)
                c = CH_DOT;
            path_chars.push_back(c);
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 10);
            for (int i = 0; i < len; i++)
                path_chars.push_back(($urandom_range(0, 4) == 0) ? CH_SLASH : name_char());
        end
        else if (sel < 91)
        begin
            // raw bytes
            repeat ($urandom_range(1, 12))
                path_chars.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            // string end inside an absolute path
            add_abs_components($urandom_range(1, 4), 5);
            path_chars.insert($urandom_range(0, path_chars.size()), CH_NUL);
            add_name($urandom_range(1, 3));
        end
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    function automatic void flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    always @(posedge clk)
    begin : result_check
        path_char_t want;
        if (rst_n && strobe !== 1'b0)
        begin
            if (expected_chars.size() == 0)
                flag_mismatch($sformatf("unexpected strobe, out_ch=%h out_last=%b",
                                        out_ch, out_last));
            else
            begin
                want = expected_chars.pop_front();
                if (out_ch !== want.ch || out_last !== want.last)
                    flag_mismatch($sformatf(
                        "expected out_ch=%h out_last=%b, got out_ch=%h out_last=%b",
                        want.ch, want.last, out_ch, out_last));
            end
        end
    end

    // watchdog on cycles with neither a request nor a result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe === 1'b1)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // empty path, zero byte first, root alone, top byte value as a relative path
    task automatic test_empty_paths();
        send_req(8'h00, 1'b1, 1'b1);
        send_req(CH_NUL, 1'b1, 1'b0);
        load_text("/");
        send_path(1'b0, 0);
        send_req(8'hFF, 1'b1, 1'b0);
    endtask

    // repeated slashes, dot, dot-dot back to root, trailing slash
    task automatic test_dot_components();
        load_text("//a/.//../b/");
        send_path(1'b0, 0);
    endtask

    // zero byte closes the component and drops the rest
    task automatic test_string_end();
        load_text("/a");
        path_chars.push_back(CH_NUL);
        path_chars.push_back("b");
        send_path(1'b0, 0);
    endtask

    // characterless requests mid path and as the closing request
    task automatic test_empty_items();
        send_req(CH_SLASH, 1'b0, 1'b0);
        send_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        send_req("c", 1'b0, 1'b0);
        send_req(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    task automatic test_random_paths(input int pct, input int n_chars);
        int base;
        gap_pct = pct;
        base    = chars_sent;
        while (chars_sent - base < n_chars)
        begin
            build_random_path();
            send_path($urandom_range(0, 9) == 0, 10);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        ch             = 8'h00;
        last           = 1'b0;
        empty_req      = 1'b0;
        gap_pct        = 7;
        chars_sent     = 0;
        mismatch_count = 0;
        stall_cycles   = 0;
        norm_clear();

        // reset, released on a falling clock edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_paths();
        test_dot_components();
        test_string_end();
        test_empty_items();
        test_random_paths(7, 80);
        test_random_paths(75, 80);
        test_random_paths(0, 80);

        @(negedge clk);
        start <= 1'b0;

        // drain outstanding results, then allow for a late pop walk
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
